// ----- sv/tsp_pkg.sv -----
package tsp_pkg;

  localparam int COUNT_WIDTH_DEF    = 24;
  localparam int POSITION_WIDTH_DEF = 32;

  localparam logic [19:0] MAX_SPEED_RST  = 20'd2000;
  localparam logic [23:0] STOP_STEPS_RST = 24'd400;
  localparam logic [27:0] SPEED_FLOOR    = 28'd256;
  localparam logic [63:0] PERIOD_NUM     = 64'd256000000;
  localparam logic [5:0]  SQ_BITS        = 6'd56;
  localparam logic [5:0]  PERIOD_BITS    = 6'd20;
  localparam logic [5:0]  ROOT_ITERS     = 6'd28;

  typedef enum logic [1:0] {
    OP_START     = 2'd0,
    OP_STEP      = 2'd1,
    OP_END_EDGE  = 2'd2,
    OP_HOME_EDGE = 2'd3
  } tsp_op_e;

  typedef enum logic [1:0] {
    REG_MAX_SPEED  = 2'd0,
    REG_STOP_STEPS = 2'd1,
    REG_HAS_LIMITS = 2'd2,
    REG_INVERT_DIR = 2'd3
  } tsp_reg_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_ACCEL  = 3'd1,
    PH_CRUISE = 3'd2,
    PH_DECEL  = 3'd3,
    PH_STOP   = 3'd4
  } tsp_phase_e;

  typedef enum logic {
    DOP_MULDIV = 1'b0,
    DOP_SQRT   = 1'b1
  } tsp_dop_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [23:0] accel_steps;
    logic [23:0] cruise_steps;
    logic [23:0] decel_steps;
    logic [27:0] cruise_speed;
    logic [31:0] accel_rate;
    logic [31:0] decel_rate;
    logic        direction;
    logic        end_switch_low;
    logic        home_switch_low;
  } tsp_in_t;

  typedef struct packed {
    logic               step_now;
    logic [19:0]        step_period_us;
    logic               dir_level;
    logic signed [31:0] position;
    logic [27:0]        speed;
    logic [2:0]         phase;
    logic               move_done;
    logic               limit_abort;
  } tsp_out_t;

  // muldiv: res = min(floor(a*b/d), 2^qw-1); sqrt: res = isqrt(a[55:0])
  typedef struct packed {
    logic        start;
    tsp_dop_e    op;
    logic [63:0] a;
    logic [31:0] b;
    logic [63:0] d;
    logic [5:0]  qw;
  } tsp_cmd_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } tsp_sts_t;

endpackage

// ----- sv/trapezoidal_step_profile_top.sv -----
// Trapezoidal stepper move sequencer.
// Input channel (in_valid_i / in_stall_o / in_data_i): one transaction per
// command: start move, next step, end limit edge or home limit edge.
// Output channel (out_valid_o / out_stall_i / out_data_o): exactly one
// result transaction per input transaction, in order.
// Config channel (cfg_valid_i / cfg_ready_o): always ready; write only while
// no command is in flight.
// Work from acceptance to the output register: start, limit-edge and idle
// next-step commands go straight to the output stage; a cruise step runs
// the period divide, an accel or decel step the product, 28-iteration root
// and 20-bit period divide in the shared arithmetic unit, and a stop-ramp
// step adds its 56-bit quotient divide. The step that enters a limit stop
// also runs the stop-length divide. One command is in work at a time; the
// next is taken the cycle after the result is registered.
// The next command is taken while a finished result waits in the output
// register; if the receiver stalls, the block holds its result and stalls
// its input once the following result is ready.
// Reset: move idle, position and counts zero, limit flags clear, config at
// max speed 2000, stop distance 400, limits on, direction not inverted.
module trapezoidal_step_profile_top #(
  parameter int COUNT_WIDTH    = tsp_pkg::COUNT_WIDTH_DEF,
  parameter int POSITION_WIDTH = tsp_pkg::POSITION_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tsp_pkg::tsp_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tsp_pkg::tsp_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [23:0]       cfg_data_i
);
  import tsp_pkg::*;

  tsp_cmd_t cmd;
  tsp_sts_t sts;

  tsp_ctrl #(
    .COUNT_WIDTH   (COUNT_WIDTH),
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  tsp_dp u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .sts_o (sts)
  );

endmodule

// ----- sv/tsp_dp.sv -----
module tsp_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tsp_pkg::tsp_cmd_t cmd_i,
  output tsp_pkg::tsp_sts_t sts_o
);
  import tsp_pkg::*;

  typedef enum logic [2:0] {
    D_IDLE, D_MLO, D_MHI, D_MSUM, D_CHK, D_DIV, D_SQRT
  } dst_e;

  dst_e        st_q, st_d;
  logic [63:0] a_q, a_d;
  logic [31:0] b_q, b_d;
  logic [63:0] d_q, d_d;
  logic [5:0]  qw_q, qw_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] pp_q, pp_d;
  logic [95:0] n_q, n_d;
  logic [63:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d;
  logic [63:0] res_q, res_d;
  logic        done_q, done_d;
  logic [55:0] sx_q, sx_d;
  logic [31:0] srem_q, srem_d;
  logic [27:0] root_q, root_d;

  logic [95:0] hi;
  logic [63:0] cap;
  logic [64:0] trial;
  logic [31:0] srem2;
  logic [31:0] strial;

  always_comb begin
    st_d   = st_q;
    a_d    = a_q;
    b_d    = b_q;
    d_d    = d_q;
    qw_d   = qw_q;
    cnt_d  = cnt_q;
    pp_d   = pp_q;
    n_d    = n_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    res_d  = res_q;
    done_d = 1'b0;
    sx_d   = sx_q;
    srem_d = srem_q;
    root_d = root_q;
    hi     = n_q >> qw_q;
    cap    = (64'd1 << qw_q) - 64'd1;
    trial  = {rem_q, n_q[{1'b0, cnt_q - 6'd1}]};
    srem2  = {srem_q[29:0], sx_q[55:54]};
    strial = {2'b00, root_q, 2'b01};
    unique case (st_q)
      D_IDLE: begin
        if (cmd_i.start) begin
          a_d  = cmd_i.a;
          b_d  = cmd_i.b;
          d_d  = cmd_i.d;
          qw_d = cmd_i.qw;
          if (cmd_i.op == DOP_SQRT) begin
            sx_d   = cmd_i.a[55:0];
            srem_d = '0;
            root_d = '0;
            cnt_d  = ROOT_ITERS;
            st_d   = D_SQRT;
          end else begin
            st_d = D_MLO;
          end
        end
      end
      D_MLO: begin
        pp_d = a_q[31:0] * b_q;
        st_d = D_MHI;
      end
      D_MHI: begin
        n_d  = {32'b0, pp_q};
        pp_d = a_q[63:32] * b_q;
        st_d = D_MSUM;
      end
      D_MSUM: begin
        n_d  = n_q + {pp_q, 32'b0};
        st_d = D_CHK;
      end
      D_CHK: begin
        // quotient would not fit in qw bits (also covers divide by zero)
        if (hi >= {32'b0, d_q}) begin
          res_d  = cap;
          done_d = 1'b1;
          st_d   = D_IDLE;
        end else if (d_q == 64'd1) begin
          res_d  = n_q[63:0];
          done_d = 1'b1;
          st_d   = D_IDLE;
        end else begin
          rem_d = hi[63:0];
          quo_d = '0;
          cnt_d = qw_q;
          st_d  = D_DIV;
        end
      end
      D_DIV: begin
        if (trial >= {1'b0, d_q}) begin
          rem_d = 64'(trial - {1'b0, d_q});
          quo_d = {quo_q[62:0], 1'b1};
        end else begin
          rem_d = trial[63:0];
          quo_d = {quo_q[62:0], 1'b0};
        end
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          res_d  = quo_d;
          done_d = 1'b1;
          st_d   = D_IDLE;
        end
      end
      D_SQRT: begin
        sx_d = {sx_q[53:0], 2'b00};
        if (srem2 >= strial) begin
          srem_d = srem2 - strial;
          root_d = {root_q[26:0], 1'b1};
        end else begin
          srem_d = srem2;
          root_d = {root_q[26:0], 1'b0};
        end
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          res_d  = {36'b0, root_d};
          done_d = 1'b1;
          st_d   = D_IDLE;
        end
      end
      default: st_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= D_IDLE;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    d_q    <= d_d;
    qw_q   <= qw_d;
    pp_q   <= pp_d;
    n_q    <= n_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    res_q  <= res_d;
    sx_q   <= sx_d;
    srem_q <= srem_d;
    root_q <= root_d;
  end

  assign sts_o.done = done_q;
  assign sts_o.res  = res_q;

endmodule

// ----- sv/tsp_ctrl.sv -----
module tsp_ctrl #(
  parameter int COUNT_WIDTH    = 24,
  parameter int POSITION_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tsp_pkg::tsp_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tsp_pkg::tsp_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [23:0]       cfg_data_i,
  output tsp_pkg::tsp_cmd_t cmd_o,
  input  tsp_pkg::tsp_sts_t sts_i
);
  import tsp_pkg::*;

  localparam int CW = COUNT_WIDTH;
  localparam int PW = POSITION_WIDTH;

  typedef enum logic [3:0] {
    S_IDLE, S_AB_VV, S_AB_DEN, S_AB_CNT, S_NUM, S_SQ, S_ROOT, S_PER, S_EMIT
  } state_e;

  state_e        state_q, state_d;
  logic [19:0]   vmax_q, vmax_d;
  logic [23:0]   lstop_q, lstop_d;
  logic          has_lim_q, has_lim_d;
  logic          inv_q, inv_d;
  tsp_phase_e    phase_q, phase_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] acnt_q, acnt_d;
  logic [CW-1:0] ccnt_q, ccnt_d;
  logic [CW-1:0] dcnt_q, dcnt_d;
  logic [CW-1:0] scnt_q, scnt_d;
  logic [27:0]   cspd_q, cspd_d;
  logic [31:0]   arate_q, arate_d;
  logic [31:0]   drate_q, drate_d;
  logic          dir_q, dir_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [27:0]   last_q, last_d;
  logic          endf_q, endf_d;
  logic          homef_q, homef_d;
  logic [63:0]   tmp_q, tmp_d;
  logic [27:0]   spd_q, spd_d;
  tsp_out_t      res_q, res_d;
  tsp_out_t      out_q, out_d;
  logic          out_valid_q, out_valid_d;
  tsp_cmd_t      cmd_q, cmd_d;

  logic [CW-1:0]        cur_cnt;
  logic [CW-1:0]        idx_inc;
  logic [27:0]          v_abort;
  logic [63:0]          vmax_sh;
  logic signed [PW-1:0] pos_s;

  function automatic logic [CW-1:0] sat_cnt(input logic [23:0] v);
    logic [32:0] w;
    w = 33'(v);
    if (w > ((33'd1 << CW) - 33'd1)) begin
      return '1;
    end
    return w[CW-1:0];
  endfunction

  function automatic logic [27:0] floor_spd(input logic [27:0] v);
    return (v < SPEED_FLOOR) ? SPEED_FLOOR : v;
  endfunction

  function automatic tsp_phase_e next_phase(input logic [2:0] from, input logic [CW-1:0] a,
                                            input logic [CW-1:0] c, input logic [CW-1:0] d);
    if (from <= 3'd1 && a != '0) return PH_ACCEL;
    if (from <= 3'd2 && c != '0) return PH_CRUISE;
    if (from <= 3'd3 && d != '0) return PH_DECEL;
    return PH_IDLE;
  endfunction

  function automatic tsp_cmd_t mk_cmd(input tsp_dop_e op, input logic [63:0] a,
                                      input logic [31:0] b, input logic [63:0] d,
                                      input logic [5:0] qw);
    tsp_cmd_t c;
    c.start = 1'b1;
    c.op    = op;
    c.a     = a;
    c.b     = b;
    c.d     = d;
    c.qw    = qw;
    return c;
  endfunction

  always_comb begin
    unique case (phase_q)
      PH_ACCEL:  cur_cnt = acnt_q;
      PH_CRUISE: cur_cnt = ccnt_q;
      PH_DECEL:  cur_cnt = dcnt_q;
      default:   cur_cnt = scnt_q;
    endcase
  end

  assign idx_inc = idx_q + 1'b1;
  assign v_abort = floor_spd(last_q);
  assign vmax_sh = 64'(vmax_q) << 16;
  assign pos_s   = pos_q;

  always_comb begin
    state_d     = state_q;
    vmax_d      = vmax_q;
    lstop_d     = lstop_q;
    has_lim_d   = has_lim_q;
    inv_d       = inv_q;
    phase_d     = phase_q;
    idx_d       = idx_q;
    acnt_d      = acnt_q;
    ccnt_d      = ccnt_q;
    dcnt_d      = dcnt_q;
    scnt_d      = scnt_q;
    cspd_d      = cspd_q;
    arate_d     = arate_q;
    drate_d     = drate_q;
    dir_d       = dir_q;
    pos_d       = pos_q;
    last_d      = last_q;
    endf_d      = endf_q;
    homef_d     = homef_q;
    tmp_d       = tmp_q;
    spd_d       = spd_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    cmd_d       = cmd_q;
    cmd_d.start = 1'b0;

    if (cfg_valid_i) begin
      unique case (tsp_reg_e'(cfg_index_i))
        REG_MAX_SPEED:  vmax_d    = cfg_data_i[19:0];
        REG_STOP_STEPS: lstop_d   = cfg_data_i;
        REG_HAS_LIMITS: has_lim_d = cfg_data_i[0];
        REG_INVERT_DIR: inv_d     = cfg_data_i[0];
        default: ;
      endcase
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_d   = '0;
          state_d = S_EMIT;
          unique case (tsp_op_e'(in_data_i.opcode))
            OP_START: begin
              acnt_d  = sat_cnt(in_data_i.accel_steps);
              ccnt_d  = sat_cnt(in_data_i.cruise_steps);
              dcnt_d  = sat_cnt(in_data_i.decel_steps);
              cspd_d  = in_data_i.cruise_speed;
              arate_d = in_data_i.accel_rate;
              drate_d = in_data_i.decel_rate;
              dir_d   = in_data_i.direction;
              scnt_d  = '0;
              idx_d   = '0;
              if (has_lim_q) begin
                if (in_data_i.direction) endf_d = in_data_i.end_switch_low;
                else                     homef_d = in_data_i.home_switch_low;
              end
              phase_d = next_phase(3'd1, acnt_d, ccnt_d, dcnt_d);
              if (phase_d == PH_CRUISE) last_d = floor_spd(in_data_i.cruise_speed);
              else if (phase_d == PH_IDLE) last_d = '0;
              res_d.phase = phase_d;
            end
            OP_END_EDGE: begin
              endf_d      = 1'b1;
              res_d.phase = phase_q;
            end
            OP_HOME_EDGE: begin
              homef_d     = 1'b1;
              res_d.phase = phase_q;
            end
            default: begin
              if (phase_q == PH_IDLE) begin
                res_d.phase = PH_IDLE;
              end else if (phase_q != PH_STOP && has_lim_q &&
                           (dir_q ? endf_q : homef_q)) begin
                idx_d       = '0;
                phase_d     = PH_STOP;
                res_d.phase = PH_STOP;
                if (lstop_q == '0 || vmax_q == '0) begin
                  // immediate stop, no step
                  scnt_d            = '0;
                  phase_d           = PH_IDLE;
                  last_d            = '0;
                  res_d.move_done   = 1'b1;
                  res_d.limit_abort = 1'b1;
                end else begin
                  cmd_d   = mk_cmd(DOP_MULDIV, 64'(v_abort), 32'(v_abort), 64'd1, SQ_BITS);
                  state_d = S_AB_VV;
                end
              end else begin
                res_d.phase = phase_q;
                unique case (phase_q)
                  PH_ACCEL: begin
                    cmd_d   = mk_cmd(DOP_MULDIV, {23'b0, arate_q, 9'b0}, 32'(idx_q),
                                     64'd1, SQ_BITS);
                    state_d = S_SQ;
                  end
                  PH_DECEL: begin
                    cmd_d   = mk_cmd(DOP_MULDIV, {23'b0, drate_q, 9'b0},
                                     32'(dcnt_q - idx_q), 64'd1, SQ_BITS);
                    state_d = S_SQ;
                  end
                  PH_CRUISE: begin
                    spd_d   = floor_spd(cspd_q);
                    cmd_d   = mk_cmd(DOP_MULDIV, PERIOD_NUM, 32'd1,
                                     64'(floor_spd(cspd_q)), PERIOD_BITS);
                    state_d = S_PER;
                  end
                  default: begin
                    cmd_d   = mk_cmd(DOP_MULDIV, vmax_sh, 32'(vmax_q), 64'd1, SQ_BITS);
                    state_d = S_NUM;
                  end
                endcase
              end
            end
          endcase
        end
      end
      S_AB_VV: begin
        if (sts_i.done) begin
          tmp_d   = sts_i.res;
          cmd_d   = mk_cmd(DOP_MULDIV, vmax_sh, 32'(vmax_q), 64'd1, SQ_BITS);
          state_d = S_AB_DEN;
        end
      end
      S_AB_DEN: begin
        if (sts_i.done) begin
          cmd_d   = mk_cmd(DOP_MULDIV, tmp_q, 32'(lstop_q), sts_i.res, 6'(CW));
          state_d = S_AB_CNT;
        end
      end
      S_AB_CNT: begin
        if (sts_i.done) begin
          scnt_d = sts_i.res[CW-1:0];
          if (sts_i.res[CW-1:0] == '0) begin
            phase_d           = PH_IDLE;
            last_d            = '0;
            res_d.move_done   = 1'b1;
            res_d.limit_abort = 1'b1;
            state_d           = S_EMIT;
          end else begin
            cmd_d   = mk_cmd(DOP_MULDIV, vmax_sh, 32'(vmax_q), 64'd1, SQ_BITS);
            state_d = S_NUM;
          end
        end
      end
      S_NUM: begin
        if (sts_i.done) begin
          cmd_d   = mk_cmd(DOP_MULDIV, sts_i.res, 32'(scnt_q - idx_q), 64'(lstop_q),
                           SQ_BITS);
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        if (sts_i.done) begin
          cmd_d   = mk_cmd(DOP_SQRT, sts_i.res, 32'd0, 64'd1, SQ_BITS);
          state_d = S_ROOT;
        end
      end
      S_ROOT: begin
        if (sts_i.done) begin
          spd_d   = floor_spd(sts_i.res[27:0]);
          cmd_d   = mk_cmd(DOP_MULDIV, PERIOD_NUM, 32'd1,
                           64'(floor_spd(sts_i.res[27:0])), PERIOD_BITS);
          state_d = S_PER;
        end
      end
      S_PER: begin
        if (sts_i.done) begin
          res_d.step_now       = 1'b1;
          res_d.step_period_us = sts_i.res[19:0];
          res_d.speed          = spd_q;
          res_d.limit_abort    = (phase_q == PH_STOP);
          pos_d                = dir_q ? pos_q + 1'b1 : pos_q - 1'b1;
          idx_d                = idx_inc;
          if (phase_q != PH_CRUISE) last_d = spd_q;
          if (idx_inc >= cur_cnt) begin
            idx_d = '0;
            if (phase_q == PH_STOP) begin
              phase_d = PH_IDLE;
              last_d  = '0;
            end else begin
              phase_d = next_phase(phase_q + 3'd1, acnt_q, ccnt_q, dcnt_q);
              if (phase_d == PH_CRUISE) last_d = floor_spd(cspd_q);
              else if (phase_d == PH_IDLE) last_d = '0;
            end
          end
          res_d.move_done = (phase_d == PH_IDLE);
          state_d         = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d           = res_q;
          out_d.dir_level = ~(dir_q ^ inv_q);
          out_d.position  = 32'(pos_s);
          out_valid_d     = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vmax_q      <= MAX_SPEED_RST;
      lstop_q     <= STOP_STEPS_RST;
      has_lim_q   <= 1'b1;
      inv_q       <= 1'b0;
      phase_q     <= PH_IDLE;
      idx_q       <= '0;
      acnt_q      <= '0;
      ccnt_q      <= '0;
      dcnt_q      <= '0;
      scnt_q      <= '0;
      cspd_q      <= '0;
      arate_q     <= '0;
      drate_q     <= '0;
      dir_q       <= 1'b0;
      pos_q       <= '0;
      last_q      <= '0;
      endf_q      <= 1'b0;
      homef_q     <= 1'b0;
      out_valid_q <= 1'b0;
      cmd_q       <= '0;
    end else begin
      state_q     <= state_d;
      vmax_q      <= vmax_d;
      lstop_q     <= lstop_d;
      has_lim_q   <= has_lim_d;
      inv_q       <= inv_d;
      phase_q     <= phase_d;
      idx_q       <= idx_d;
      acnt_q      <= acnt_d;
      ccnt_q      <= ccnt_d;
      dcnt_q      <= dcnt_d;
      scnt_q      <= scnt_d;
      cspd_q      <= cspd_d;
      arate_q     <= arate_d;
      drate_q     <= drate_d;
      dir_q       <= dir_d;
      pos_q       <= pos_d;
      last_q      <= last_d;
      endf_q      <= endf_d;
      homef_q     <= homef_d;
      out_valid_q <= out_valid_d;
      cmd_q       <= cmd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tmp_q <= tmp_d;
    spd_q <= spd_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;
  assign cmd_o       = cmd_q;

endmodule

// ----- tb/sv/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tsp_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [63:0] SQ_MAX = (64'd1 << 56) - 1;
  localparam logic [63:0] CNT_MAX = (64'd1 << 24) - 1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  tsp_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  tsp_out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;

  trapezoidal_step_profile_top dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [63:0] c_vmax, c_lstop, c_limits, c_inv;
  tsp_phase_e m_phase;
  logic [63:0] m_idx, m_acc, m_cru, m_dec, m_stop, m_cspd, m_arate, m_drate, m_pos, m_last;
  logic m_dir, m_endf, m_homef;

  tsp_in_t pending_items[$];
  tsp_out_t expected_results[$];
  int sender_idle_pct, receiver_idle_pct;
  int errors = 0, steps_seen = 0, aborts_seen = 0, results_seen = 0;
  int quiet_cycles = 0;

  function automatic logic [63:0] mul_div_sat(logic [63:0] a, logic [63:0] b, logic [63:0] d,
                                              logic [63:0] cap);
    logic [127:0] p;
    if (d == 0) return cap;
    p = (128'(a) * 128'(b)) / 128'(d);
    return (p > 128'(cap)) ? cap : p[63:0];
  endfunction

  function automatic logic [63:0] int_root(logic [63:0] x);
    logic [63:0] r, one;
    r = 0;
    one = 64'd1 << 62;
    while (one > x) one >>= 2;
    while (one != 0) begin
      if (x >= r + one) begin
        x -= r + one;
        r = (r >> 1) + one;
      end else begin
        r >>= 1;
      end
      one >>= 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] floored(logic [63:0] v);
    v &= 64'hFFFFFFF;
    return (v < 256) ? 64'd256 : v;
  endfunction

  function automatic logic [63:0] speed_from_sq(logic [63:0] sq);
    logic [63:0] v;
    v = int_root(sq);
    if (v > 64'hFFFFFFF) v = 64'hFFFFFFF;
    return floored(v);
  endfunction

  function automatic void advance_phase(int from);
    m_idx = 0;
    if (from <= 1 && m_acc != 0) m_phase = PH_ACCEL;
    else if (from <= 2 && m_cru != 0) begin
      m_phase = PH_CRUISE;
      m_last = floored(m_cspd);
    end else if (from <= 3 && m_dec != 0) m_phase = PH_DECEL;
    else begin
      m_phase = PH_IDLE;
      m_last = 0;
    end
  endfunction

  function automatic tsp_out_t predict_motion(tsp_in_t it);
    tsp_out_t r;
    logic [63:0] spd, cnt, v, den;
    logic stop_now;
    r = '0;
    spd = 0;
    case (tsp_op_e'(it.opcode))
      OP_START: begin
        m_acc = 64'(it.accel_steps);
        m_cru = 64'(it.cruise_steps);
        m_dec = 64'(it.decel_steps);
        m_cspd = 64'(it.cruise_speed);
        m_arate = 64'(it.accel_rate);
        m_drate = 64'(it.decel_rate);
        m_dir = it.direction;
        m_stop = 0;
        if (c_limits[0]) begin
          if (m_dir) m_endf = it.end_switch_low;
          else m_homef = it.home_switch_low;
        end
        advance_phase(1);
        r.phase = m_phase;
      end
      OP_END_EDGE: begin
        m_endf = 1'b1;
        r.phase = m_phase;
      end
      OP_HOME_EDGE: begin
        m_homef = 1'b1;
        r.phase = m_phase;
      end
      default: begin
        if (m_phase != PH_IDLE) begin
          stop_now = 1'b0;
          if (m_phase <= PH_DECEL && c_limits[0] && (m_dir ? m_endf : m_homef)) begin
            v = floored(m_last);
            den = (c_vmax * c_vmax) << 16;
            if (c_lstop == 0 || c_vmax == 0) m_stop = 0;
            else m_stop = mul_div_sat(v * v, c_lstop, den, CNT_MAX);
            m_idx = 0;
            m_phase = PH_STOP;
            if (m_stop == 0) stop_now = 1'b1;
          end
          r.phase = m_phase;
          if (stop_now) begin
            m_phase = PH_IDLE;
            m_idx = 0;
            m_last = 0;
            r.move_done = 1'b1;
            r.limit_abort = 1'b1;
          end else begin
            case (m_phase)
              PH_ACCEL: begin
                spd = speed_from_sq(mul_div_sat(m_arate << 9, m_idx, 1, SQ_MAX));
                cnt = m_acc;
              end
              PH_CRUISE: begin
                spd = floored(m_cspd);
                cnt = m_cru;
              end
              PH_DECEL: begin
                spd = speed_from_sq(mul_div_sat(m_drate << 9, m_dec - m_idx, 1, SQ_MAX));
                cnt = m_dec;
              end
              default: begin
                spd = speed_from_sq(mul_div_sat((c_vmax * c_vmax) << 16, m_stop - m_idx,
                                                c_lstop, SQ_MAX));
                cnt = m_stop;
                r.limit_abort = 1'b1;
              end
            endcase
            r.step_period_us = 20'(64'd256000000 / spd);
            r.step_now = 1'b1;
            m_pos = (m_pos + (m_dir ? 64'd1 : 64'hFFFFFFFF)) & 64'hFFFFFFFF;
            m_idx++;
            if (m_phase != PH_CRUISE) m_last = spd;
            if (m_idx >= cnt) begin
              if (m_phase == PH_STOP) begin
                m_phase = PH_IDLE;
                m_idx = 0;
                m_last = 0;
              end else begin
                advance_phase(int'(m_phase) + 1);
              end
            end
            r.move_done = (m_phase == PH_IDLE);
          end
        end
      end
    endcase
    r.speed = spd[27:0];
    r.position = m_pos[31:0];
    r.dir_level = ~(m_dir ^ c_inv[0]);
    return r;
  endfunction

  // driver: the item at the front of the queue is the one on the bus
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      expected_results.push_back(predict_motion(in_data_i));
      void'(pending_items.pop_front());
    end
    if ((!in_valid_i || !in_stall_o)) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_items[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= ($urandom_range(99) < receiver_idle_pct);
  end

  // monitor
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: %p", out_data_o);
        errors++;
      end else begin
        tsp_out_t e;
        e = expected_results.pop_front();
        if (out_data_o.step_now && out_data_o.phase == PH_STOP) aborts_seen++;
        if (out_data_o.step_now) steps_seen++;
        if (e.step_now !== out_data_o.step_now) begin
          $error("step_now exp %0d got %0d", e.step_now, out_data_o.step_now); errors++;
        end
        if (e.step_period_us !== out_data_o.step_period_us) begin
          $error("step_period_us exp %0d got %0d", e.step_period_us,
                 out_data_o.step_period_us); errors++;
        end
        if (e.dir_level !== out_data_o.dir_level) begin
          $error("dir_level exp %0d got %0d", e.dir_level, out_data_o.dir_level); errors++;
        end
        if (e.position !== out_data_o.position) begin
          $error("position exp %0d got %0d", e.position, out_data_o.position); errors++;
        end
        if (e.speed !== out_data_o.speed) begin
          $error("speed exp %0d got %0d", e.speed, out_data_o.speed); errors++;
        end
        if (e.phase !== out_data_o.phase) begin
          $error("phase exp %0d got %0d", e.phase, out_data_o.phase); errors++;
        end
        if (e.move_done !== out_data_o.move_done) begin
          $error("move_done exp %0d got %0d", e.move_done, out_data_o.move_done); errors++;
        end
        if (e.limit_abort !== out_data_o.limit_abort) begin
          $error("limit_abort exp %0d got %0d", e.limit_abort, out_data_o.limit_abort);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (pending_items.size() == 0 && expected_results.size() == 0)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic write_reg(tsp_reg_e idx, logic [23:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_MAX_SPEED: c_vmax = 64'(val[19:0]);
      REG_STOP_STEPS: c_lstop = 64'(val);
      REG_HAS_LIMITS: c_limits = 64'(val[0]);
      default: c_inv = 64'(val[0]);
    endcase
  endtask

  task automatic drain;
    wait (pending_items.size() == 0 && expected_results.size() == 0);
    repeat (150) @(posedge clk_i);
  endtask

  function automatic tsp_in_t make_item(tsp_op_e op);
    tsp_in_t it;
    it.opcode = op;
    it.accel_steps = 24'($urandom_range(12));
    it.cruise_steps = 24'($urandom_range(8));
    it.decel_steps = 24'($urandom_range(12));
    case ($urandom_range(3))
      0: it.cruise_speed = 28'($urandom);
      1: it.cruise_speed = 28'($urandom_range(300));
      default: it.cruise_speed = 28'($urandom_range(256 * 4000));
    endcase
    it.accel_rate = ($urandom_range(3) == 0) ? $urandom : $urandom_range(256 * 50000);
    it.decel_rate = ($urandom_range(3) == 0) ? $urandom : $urandom_range(256 * 50000);
    if ($urandom_range(15) == 0) begin
      it.accel_steps = 24'($urandom);
      it.cruise_steps = 24'($urandom);
      it.decel_steps = 24'($urandom);
    end
    it.direction = 1'($urandom);
    it.end_switch_low = ($urandom_range(5) == 0);
    it.home_switch_low = ($urandom_range(5) == 0);
    return it;
  endfunction

  // a well-formed move: start, then its steps with an occasional limit edge
  task automatic queue_move();
    tsp_in_t it;
    int n;
    it = make_item(OP_START);
    pending_items.push_back(it);
    n = it.accel_steps + it.cruise_steps + it.decel_steps;
    if (n > 40) n = $urandom_range(40, 10);
    else n = n + $urandom_range(2);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(30) == 0) begin
        it = make_item($urandom_range(1) ? OP_END_EDGE : OP_HOME_EDGE);
        pending_items.push_back(it);
      end
      it = make_item(OP_STEP);
      pending_items.push_back(it);
    end
  endtask

  task automatic queue_random(int count);
    int queued;
    tsp_in_t it;
    queued = pending_items.size();
    while (pending_items.size() - queued < count) begin
      if ($urandom_range(9) < 8) queue_move();
      else begin
        it = make_item(tsp_op_e'($urandom_range(3)));
        pending_items.push_back(it);
      end
    end
  endtask

  initial begin
    tsp_in_t it;
    c_vmax = 2000; c_lstop = 400; c_limits = 1; c_inv = 0;
    m_phase = PH_IDLE;
    {m_idx, m_acc, m_cru, m_dec, m_stop, m_cspd, m_arate, m_drate, m_pos, m_last} = '0;
    {m_dir, m_endf, m_homef} = '0;
    sender_idle_pct = 9;
    receiver_idle_pct = 61;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: step while idle, extremes, zero cruise speed, abort with ramp and instant stop
    it = '0; it.opcode = OP_STEP; pending_items.push_back(it);
    it = '0; it.opcode = OP_START; pending_items.push_back(it);
    it = '0; it.opcode = OP_START; it.accel_steps = 2; it.cruise_steps = 2; it.decel_steps = 2;
    it.cruise_speed = 0; it.accel_rate = '1; it.decel_rate = 32'd256; it.direction = 1;
    pending_items.push_back(it);
    repeat (3) begin it = '0; it.opcode = OP_STEP; pending_items.push_back(it); end
    it = '0; it.opcode = OP_END_EDGE; pending_items.push_back(it);
    repeat (3) begin it = '0; it.opcode = OP_STEP; pending_items.push_back(it); end
    it = '1; it.opcode = OP_START; pending_items.push_back(it);
    repeat (4) begin it = '1; it.opcode = OP_STEP; pending_items.push_back(it); end
    it = '1; it.opcode = OP_HOME_EDGE; pending_items.push_back(it);
    it = '0; it.opcode = OP_START; it.cruise_steps = 3; it.cruise_speed = 28'hFFFFFFF;
    it.home_switch_low = 1; pending_items.push_back(it);
    repeat (2) begin it = '0; it.opcode = OP_STEP; pending_items.push_back(it); end
    drain();

    write_reg(REG_STOP_STEPS, 24'd0);
    write_reg(REG_INVERT_DIR, 24'd1);
    queue_random(150);
    drain();
    write_reg(REG_MAX_SPEED, 24'd0);
    write_reg(REG_STOP_STEPS, 24'hFFFFFF);
    write_reg(REG_HAS_LIMITS, 24'd0);
    queue_random(150);
    drain();
    sender_idle_pct = 61;
    receiver_idle_pct = 9;
    write_reg(REG_MAX_SPEED, 24'd1000000);
    write_reg(REG_STOP_STEPS, 24'd30);
    write_reg(REG_HAS_LIMITS, 24'd1);
    write_reg(REG_INVERT_DIR, 24'd0);
    queue_random(400);
    drain();
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    write_reg(REG_MAX_SPEED, 24'd1);
    write_reg(REG_STOP_STEPS, 24'd5);
    queue_random(200);
    drain();
    write_reg(REG_MAX_SPEED, 24'd2000);
    write_reg(REG_STOP_STEPS, 24'd400);
    queue_random(450);
    drain();

    $display("%0d results checked, %0d step pulses, %0d limit stop steps",
             results_seen, steps_seen, aborts_seen);
    $display("moves ran under six register settings with sender and receiver stalls");
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
